FILE: hw/rtl/f4sbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f4sbc_pkg
// Shared types and constants of the bias-corrected f4 statistic core.
// ----------------------------------------------------------------------------
package f4sbc_pkg;

    localparam int COUNT_W   = 12;
    localparam int POP_W     = 8;
    localparam int NUM_POPS  = 4;

    // Q30 fraction bits produced by the first divider, one extra for rounding.
    localparam int FRAC_Q_W  = 31;
    // Quotient bits of the h/n divider.
    localparam int HN_Q_W    = 32;
    // Width of a rounded Q30 value in 0..2^30.
    localparam int Q30_W     = 31;

    // Lane latency: product register, fraction divider, rounding register,
    // h/n divider, output register.
    localparam int LANE_LAT  = 1 + FRAC_Q_W + 1 + HN_Q_W + 1;
    localparam int MERGE_LAT = 2;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    localparam logic [Q30_W-1:0] ONE_Q30 = Q30_W'(1) << 30;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_BADPOP  = 2'd2,
        ST_FEW     = 2'd3
    } t_status;

    typedef struct packed {
        logic        [COUNT_W-1:0] ref_count_a;
        logic        [COUNT_W-1:0] alt_count_a;
        logic        [COUNT_W-1:0] ref_count_b;
        logic        [COUNT_W-1:0] alt_count_b;
        logic        [COUNT_W-1:0] ref_count_c;
        logic        [COUNT_W-1:0] alt_count_c;
        logic        [COUNT_W-1:0] ref_count_d;
        logic        [COUNT_W-1:0] alt_count_d;
        logic signed [POP_W-1:0]   pop_a;
        logic signed [POP_W-1:0]   pop_b;
        logic signed [POP_W-1:0]   pop_c;
        logic signed [POP_W-1:0]   pop_d;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] f4_value;
        t_status            status;
    } t_out_req;

    // Per-request decisions that travel beside the lanes.
    typedef struct packed {
        t_status status;
        logic    eq_ac;
        logic    eq_ad;
        logic    eq_bd;
        logic    eq_bc;
    } t_side;

endpackage

FILE: hw/rtl/f4sbc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f4sbc_div
// Pipelined restoring divider, one quotient bit per registered stage.
// ----------------------------------------------------------------------------
module f4sbc_div #(
    parameter int DEN_W = 13,
    parameter int Q_W   = 31,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [DEN_W-1:0] i_den,
    input  logic [Q_W-1:0]   i_bits,
    input  logic [TAG_W-1:0] i_tag,
    output logic [Q_W-1:0]   o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [DEN_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_bits[Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];
    logic [TAG_W-1:0] r_tag [Q_W];

    logic [DEN_W-1:0] n_rem [Q_W];
    logic [Q_W-1:0]   n_bits[Q_W];
    logic [Q_W-1:0]   n_quo [Q_W];

    always_comb begin
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [Q_W-1:0]   s_bits;
        logic [Q_W-1:0]   s_quo;
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                s_rem  = i_rem;
                s_den  = i_den;
                s_bits = i_bits;
                s_quo  = '0;
            end else begin
                s_rem  = r_rem[k-1];
                s_den  = r_den[k-1];
                s_bits = r_bits[k-1];
                s_quo  = r_quo[k-1];
            end
            t = {s_rem, s_bits[Q_W-1]};
            if (t >= {1'b0, s_den}) begin
                t        = t - {1'b0, s_den};
                n_quo[k] = {s_quo[Q_W-2:0], 1'b1};
            end else begin
                n_quo[k] = {s_quo[Q_W-2:0], 1'b0};
            end
            n_rem[k]  = t[DEN_W-1:0];
            n_bits[k] = s_bits << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Q_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_bits[k] <= n_bits[k];
                r_quo[k]  <= n_quo[k];
                r_den[k]  <= (k == 0) ? i_den : r_den[k-1];
                r_tag[k]  <= (k == 0) ? i_tag : r_tag[k-1];
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];
    assign o_tag = r_tag[Q_W-1];

endmodule

FILE: hw/rtl/f4sbc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f4sbc_lane
// One population: allele frequency and heterozygosity term h/n in Q30.
// ----------------------------------------------------------------------------
module f4sbc_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [f4sbc_pkg::COUNT_W-1:0] i_ref,
    input  logic [f4sbc_pkg::COUNT_W-1:0] i_alt,
    output logic [f4sbc_pkg::Q30_W-1:0]   o_p,
    output logic [f4sbc_pkg::Q30_W-1:0]   o_hn
);

    localparam int CW   = f4sbc_pkg::COUNT_W;
    localparam int NW   = CW + 1;
    localparam int HW   = 2 * CW + 2;
    localparam int QW   = f4sbc_pkg::Q30_W;
    localparam int FQ   = f4sbc_pkg::FRAC_Q_W;
    localparam int HQ   = f4sbc_pkg::HN_Q_W;

    logic [NW-1:0]   n_sum;
    logic [CW-1:0]   r_ref;
    logic [NW-1:0]   r_n;
    logic [HW-1:0]   r_ra;
    logic [HW-1:0]   r_nn1;

    assign n_sum = NW'(i_ref) + NW'(i_alt);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ref <= i_ref;
            r_n   <= n_sum;
            r_ra  <= HW'(i_ref) * HW'(i_alt);
            r_nn1 <= HW'(n_sum) * HW'(n_sum - NW'(1));
        end
    end

    // A numerator equal to the denominator yields exactly one.
    logic          p_full;
    logic          h_full;
    logic [FQ-1:0] p_quo;
    logic [FQ-1:0] h_quo;
    logic          p_full_q;
    logic [NW:0]   h_tag_q;

    assign p_full = (NW'(r_ref) >= r_n);
    assign h_full = (r_ra >= r_nn1);

    f4sbc_div #(.DEN_W(NW), .Q_W(FQ), .TAG_W(1)) u_div_p (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rem  (p_full ? '0 : NW'(r_ref)),
        .i_den  (r_n),
        .i_bits ('0),
        .i_tag  (p_full),
        .o_quo  (p_quo),
        .o_tag  (p_full_q)
    );

    f4sbc_div #(.DEN_W(HW), .Q_W(FQ), .TAG_W(NW + 1)) u_div_h (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rem  (h_full ? '0 : r_ra),
        .i_den  (r_nn1),
        .i_bits ('0),
        .i_tag  ({h_full, r_n}),
        .o_quo  (h_quo),
        .o_tag  (h_tag_q)
    );

    logic [QW:0]     p_inc;
    logic [QW:0]     h_inc;
    logic [QW-1:0]   r_p;
    logic [HQ-1:0]   r_hnum;
    logic [NW:0]     r_hden;
    logic [QW-1:0]   hq;

    assign p_inc = (QW + 1)'(p_quo) + (QW + 1)'(1);
    assign h_inc = (QW + 1)'(h_quo) + (QW + 1)'(1);
    assign hq    = h_tag_q[NW] ? f4sbc_pkg::ONE_Q30 : h_inc[QW:1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= p_full_q ? f4sbc_pkg::ONE_Q30 : p_inc[QW:1];
            r_hnum <= {hq, 1'b0} + HQ'(h_tag_q[NW-1:0]);
            r_hden <= {h_tag_q[NW-1:0], 1'b0};
        end
    end

    logic [HQ-1:0] hn_quo;
    logic [QW-1:0] p_late;

    f4sbc_div #(.DEN_W(NW + 1), .Q_W(HQ), .TAG_W(QW)) u_div_hn (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rem  ('0),
        .i_den  (r_hden),
        .i_bits (r_hnum),
        .i_tag  (r_p),
        .o_quo  (hn_quo),
        .o_tag  (p_late)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p  <= p_late;
            o_hn <= hn_quo[QW-1:0];
        end
    end

endmodule

FILE: hw/rtl/f4sbc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f4sbc_merge
// Combines the lane results into the corrected, saturated f4 value.
// ----------------------------------------------------------------------------
module f4sbc_merge (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [f4sbc_pkg::Q30_W-1:0] i_p [f4sbc_pkg::NUM_POPS],
    input  logic [f4sbc_pkg::Q30_W-1:0] i_hn_a,
    input  logic [f4sbc_pkg::Q30_W-1:0] i_hn_b,
    input  f4sbc_pkg::t_side            i_side,
    output f4sbc_pkg::t_out_req         o_data
);

    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic signed [33:0] ha;
    logic signed [33:0] hb;
    logic signed [33:0] corr;
    logic signed [63:0] r_prod;
    logic signed [33:0] r_corr;
    f4sbc_pkg::t_side   r_side;

    assign d1 = signed'({1'b0, i_p[0]}) - signed'({1'b0, i_p[1]});
    assign d2 = signed'({1'b0, i_p[2]}) - signed'({1'b0, i_p[3]});

    // The heterozygosity correction is summed beside the product.
    always_comb begin
        ha   = signed'({3'b000, i_hn_a});
        hb   = signed'({3'b000, i_hn_b});
        corr = '0;
        if (i_side.eq_ac) corr = corr - ha;
        if (i_side.eq_ad) corr = corr + ha;
        if (i_side.eq_bd) corr = corr - hb;
        if (i_side.eq_bc) corr = corr + hb;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 64'(d1) * 64'(d2);
            r_corr <= corr;
            r_side <= i_side;
        end
    end

    logic signed [63:0] prod_rnd;
    logic signed [33:0] val;
    logic signed [31:0] sat;

    // Rounding to nearest with ties away from zero: a negative product adds
    // one less than half, so that its ties round downward.
    always_comb begin
        prod_rnd = r_prod + (r_prod[63] ? 64'sd536870911 : 64'sd536870912);
        val      = signed'(prod_rnd[63:30]) + r_corr;
        if (val > 34'sd2147483647) begin
            sat = 32'sh7FFF_FFFF;
        end else if (val < -34'sd2147483648) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = val[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data.status <= r_side.status;
            case (r_side.status)
                f4sbc_pkg::ST_OK:     o_data.f4_value <= sat;
                f4sbc_pkg::ST_BADPOP: o_data.f4_value <= 32'(f4sbc_pkg::ONE_Q30);
                default:              o_data.f4_value <= '0;
            endcase
        end
    end

endmodule

FILE: hw/rtl/f4_statistic_bias_corrected_core.sv
`timescale 1ns / 1ps
// Each result passes through the lane pipeline and then the merge registers.
// Throughput: one request per cycle while the output is not stalled; every stage
// of the 31- and 32-bit one-bit-per-stage divider pipelines holds its own request.
// Reset: synchronous, active low; clears the stage valid bits only.
// The whole pipeline holds while the output register is full and not taken.
// ----------------------------------------------------------------------------
// f4_statistic_bias_corrected_core
// f4 statistic with heterozygosity correction for one SNP per request.
// ----------------------------------------------------------------------------
module f4_statistic_bias_corrected_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  f4sbc_pkg::t_in_req  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output f4sbc_pkg::t_out_req o_data
);

    localparam int NP   = f4sbc_pkg::NUM_POPS;
    localparam int CW   = f4sbc_pkg::COUNT_W;
    localparam int PW   = f4sbc_pkg::POP_W;
    localparam int LL   = f4sbc_pkg::LANE_LAT;
    localparam int TL   = f4sbc_pkg::TOTAL_LAT;
    localparam int QW   = f4sbc_pkg::Q30_W;

    // Every stage advances together; the pipeline moves whenever the last
    // stage is empty or its result is being taken.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Unpack the request into per-population arrays, A through D.
    logic [CW-1:0] cnt_ref [NP];
    logic [CW-1:0] cnt_alt [NP];
    logic [PW-1:0] idx     [NP];

    assign cnt_ref[0] = i_data.ref_count_a;
    assign cnt_ref[1] = i_data.ref_count_b;
    assign cnt_ref[2] = i_data.ref_count_c;
    assign cnt_ref[3] = i_data.ref_count_d;
    assign cnt_alt[0] = i_data.alt_count_a;
    assign cnt_alt[1] = i_data.alt_count_b;
    assign cnt_alt[2] = i_data.alt_count_c;
    assign cnt_alt[3] = i_data.alt_count_d;
    assign idx[0]     = i_data.pop_a;
    assign idx[1]     = i_data.pop_b;
    assign idx[2]     = i_data.pop_c;
    assign idx[3]     = i_data.pop_d;

    // Status is decided up front. Populations are checked in order and the
    // first one with a negative index or an empty count decides it; after
    // that a single allele at A or B means too few alleles.
    f4sbc_pkg::t_side side;

    always_comb begin
        logic found;
        found       = 1'b0;
        side.status = f4sbc_pkg::ST_OK;
        for (int k = 0; k < NP; k++) begin
            if (!found) begin
                if (idx[k][PW-1]) begin
                    side.status = f4sbc_pkg::ST_BADPOP;
                    found       = 1'b1;
                end else if (cnt_ref[k] == '0 && cnt_alt[k] == '0) begin
                    side.status = f4sbc_pkg::ST_MISSING;
                    found       = 1'b1;
                end
            end
        end
        if (!found && ((CW + 1)'(cnt_ref[0]) + (CW + 1)'(cnt_alt[0]) <= (CW + 1)'(1)
                    || (CW + 1)'(cnt_ref[1]) + (CW + 1)'(cnt_alt[1]) <= (CW + 1)'(1))) begin
            side.status = f4sbc_pkg::ST_FEW;
        end
        side.eq_ac = (idx[0] == idx[2]);
        side.eq_ad = (idx[0] == idx[3]);
        side.eq_bd = (idx[1] == idx[3]);
        side.eq_bc = (idx[1] == idx[2]);
    end

    // Four identical lanes, one per population.
    logic [QW-1:0] lane_p  [NP];
    logic [QW-1:0] lane_hn [NP];

    for (genvar g = 0; g < NP; g++) begin : g_lane
        f4sbc_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_ref (cnt_ref[g]),
            .i_alt (cnt_alt[g]),
            .o_p   (lane_p[g]),
            .o_hn  (lane_hn[g])
        );
    end

    // Status and index matches ride alongside the lanes.
    f4sbc_pkg::t_side r_side [LL];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < LL; k++) begin
                r_side[k] <= (k == 0) ? side : r_side[k-1];
            end
        end
    end

    // Only the heterozygosity terms of A and B enter the correction.
    f4sbc_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_p    (lane_p),
        .i_hn_a (lane_hn[0]),
        .i_hn_b (lane_hn[1]),
        .i_side (r_side[LL-1]),
        .o_data (o_data)
    );

    // Valid bit for every pipeline stage.
    logic r_vld [TL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TL; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < TL; k++) begin
                r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
            end
        end
    end

    assign o_valid = r_vld[TL-1];

endmodule
